// ----- hw/rtl/lcfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED cube frame scanner package
// Shared constants, command codes and the command structure for the scanner.
// ----------------------------------------------------------------------------
package lcfs_pkg;

	// Cube geometry.
	localparam int NUM_LAYERS = 3;
	localparam int NUM_ROWS   = 3;
	localparam int NUM_COLS   = 3;
	localparam int NUM_CELLS  = NUM_ROWS * NUM_COLS;
	localparam int NUM_VOXELS = NUM_LAYERS * NUM_CELLS;
	localparam int VOX_IDX_W  = $clog2(NUM_VOXELS);

	// Brightness levels and step flags.
	localparam logic [1:0] LEVEL_MIN = 2'd0;
	localparam logic [1:0] LEVEL_MAX = 2'd3;
	localparam logic [1:0] FLAG_DOWN = 2'd1;
	localparam logic [1:0] FLAG_UP   = 2'd2;

	// Configuration register indexes and reset values.
	localparam logic [1:0] CFG_PWM_PERIOD = 2'd0;
	localparam logic [1:0] CFG_DIM_ON     = 2'd1;
	localparam logic [1:0] CFG_MID_ON     = 2'd2;
	localparam logic [1:0] CFG_FULL_ON    = 2'd3;

	localparam logic [7:0] PWM_PERIOD_RST = 8'd100;
	localparam logic [7:0] DIM_ON_RST     = 8'd1;
	localparam logic [7:0] MID_ON_RST     = 8'd10;
	localparam logic [7:0] FULL_ON_RST    = 8'd100;

	// Shift axes.
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Command codes; code 7 is unused and does nothing.
	typedef enum logic [2:0] {
		MODE_SCAN     = 3'd0,
		MODE_WR_LEVEL = 3'd1,
		MODE_RD_LEVEL = 3'd2,
		MODE_WR_FLAG  = 3'd3,
		MODE_RD_FLAG  = 3'd4,
		MODE_STEP     = 3'd5,
		MODE_SHIFT    = 3'd6
	} mode_t;

	// One command as it travels from the input stage to the voxel store.
	typedef struct packed {
		mode_t      mode;
		logic [1:0] layer;
		logic [3:0] cell_idx;
		logic [1:0] value;
		logic [1:0] axis;
		logic       up;
		logic       wrap;
	} cmd_t;

endpackage

// ----- hw/rtl/lcfs_voxel_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED cube voxel store
// Holds the 27 brightness levels and step flags, applies one command per
// cycle while apply is high, presenting the updated levels of view_layer.
// ----------------------------------------------------------------------------
module lcfs_voxel_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcfs_pkg::cmd_t       cmd,
	input  logic                 apply,
	input  logic [1:0]           view_layer,
	output logic [8:0][1:0]      row_levels,
	output logic [1:0]           read_data
);
	import lcfs_pkg::*;

	logic [1:0] levels_q  [NUM_VOXELS];
	logic [1:0] flags_q   [NUM_VOXELS];
	logic [1:0] levels_nx [NUM_VOXELS];
	logic [1:0] flags_nx  [NUM_VOXELS];
	logic [1:0] shift_x   [NUM_VOXELS];
	logic [1:0] shift_y   [NUM_VOXELS];
	logic [1:0] shift_z   [NUM_VOXELS];
	logic [1:0] stepped   [NUM_VOXELS];
	logic                 addr_ok;
	logic [VOX_IDX_W-1:0] addr;

	// Address decode: layer times nine plus cell, only for in-range requests.
	always_comb begin
		addr_ok = (cmd.layer < 2'(NUM_LAYERS)) && (cmd.cell_idx < 4'(NUM_CELLS));
		addr    = addr_ok ? ((VOX_IDX_W'(cmd.layer) << 3) + VOX_IDX_W'(cmd.layer)
			+ VOX_IDX_W'(cmd.cell_idx)) : '0;
	end

	// Shifted copies of the cube along each axis, one line of three at a time.
	always_comb begin
		int idx;
		int src_up;
		int src_dn;
		for (int l = 0; l < NUM_LAYERS; l++) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				for (int c = 0; c < NUM_COLS; c++) begin
					idx = l * NUM_CELLS + r * NUM_COLS + c;
					// Along x, stride one.
					src_up = (c > 0) ? idx - 1 : idx + 2;
					src_dn = (c < 2) ? idx + 1 : idx - 2;
					if (cmd.up) begin
						shift_x[idx] = (c == 0 && !cmd.wrap) ? 2'd0 :
							levels_q[VOX_IDX_W'(src_up)];
					end else begin
						shift_x[idx] = (c == 2 && !cmd.wrap) ? 2'd0 :
							levels_q[VOX_IDX_W'(src_dn)];
					end
					// Along y, stride one row.
					src_up = (r > 0) ? idx - NUM_COLS : idx + 2 * NUM_COLS;
					src_dn = (r < 2) ? idx + NUM_COLS : idx - 2 * NUM_COLS;
					if (cmd.up) begin
						shift_y[idx] = (r == 0 && !cmd.wrap) ? 2'd0 :
							levels_q[VOX_IDX_W'(src_up)];
					end else begin
						shift_y[idx] = (r == 2 && !cmd.wrap) ? 2'd0 :
							levels_q[VOX_IDX_W'(src_dn)];
					end
					// Along z, stride one layer.
					src_up = (l > 0) ? idx - NUM_CELLS : idx + 2 * NUM_CELLS;
					src_dn = (l < 2) ? idx + NUM_CELLS : idx - 2 * NUM_CELLS;
					if (cmd.up) begin
						shift_z[idx] = (l == 0 && !cmd.wrap) ? 2'd0 :
							levels_q[VOX_IDX_W'(src_up)];
					end else begin
						shift_z[idx] = (l == 2 && !cmd.wrap) ? 2'd0 :
							levels_q[VOX_IDX_W'(src_dn)];
					end
				end
			end
		end
	end

	// Saturating step of every level by its own flag; other flags hold.
	always_comb begin
		for (int i = 0; i < NUM_VOXELS; i++) begin
			stepped[i] = levels_q[i];
			if (flags_q[i] == FLAG_UP && levels_q[i] != LEVEL_MAX) begin
				stepped[i] = levels_q[i] + 2'd1;
			end else if (flags_q[i] == FLAG_DOWN && levels_q[i] != LEVEL_MIN) begin
				stepped[i] = levels_q[i] - 2'd1;
			end
		end
	end

	// Next state of the whole store for the command at hand.
	always_comb begin
		for (int i = 0; i < NUM_VOXELS; i++) begin
			levels_nx[i] = levels_q[i];
			flags_nx[i]  = flags_q[i];
			if (apply) begin
				unique case (cmd.mode)
					MODE_WR_LEVEL: begin
						if (addr_ok && addr == VOX_IDX_W'(i)) begin
							levels_nx[i] = cmd.value;
						end
					end
					MODE_WR_FLAG: begin
						if (addr_ok && addr == VOX_IDX_W'(i)) begin
							flags_nx[i] = cmd.value;
						end
					end
					MODE_STEP: begin
						levels_nx[i] = stepped[i];
					end
					MODE_SHIFT: begin
						priority if (cmd.axis == AXIS_X) begin
							levels_nx[i] = shift_x[i];
						end else if (cmd.axis == AXIS_Y) begin
							levels_nx[i] = shift_y[i];
						end else if (cmd.axis == AXIS_Z) begin
							levels_nx[i] = shift_z[i];
						end else begin
							levels_nx[i] = levels_q[i];
						end
					end
					default: begin
						levels_nx[i] = levels_q[i];
					end
				endcase
			end
		end
	end

	// Store registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOXELS; i++) begin
				levels_q[i] <= '0;
				flags_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_VOXELS; i++) begin
				levels_q[i] <= levels_nx[i];
				flags_q[i]  <= flags_nx[i];
			end
		end
	end

	// Read back; reads do not change the store, so the current contents serve.
	always_comb begin
		read_data = 2'd0;
		if (addr_ok && cmd.mode == MODE_RD_LEVEL) begin
			read_data = levels_q[addr];
		end else if (addr_ok && cmd.mode == MODE_RD_FLAG) begin
			read_data = flags_q[addr];
		end
	end

	// Updated levels of the layer being scanned.
	always_comb begin
		for (int j = 0; j < NUM_CELLS; j++) begin
			if (view_layer == 2'd1) begin
				row_levels[j] = levels_nx[NUM_CELLS + j];
			end else if (view_layer == 2'd2) begin
				row_levels[j] = levels_nx[2 * NUM_CELLS + j];
			end else begin
				row_levels[j] = levels_nx[j];
			end
		end
	end

endmodule

// ----- hw/rtl/led_cube_frame_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED cube frame scanner
// Command front end, PWM scan counters and column drive of a 3x3x3 LED cube.
// ----------------------------------------------------------------------------
// Throughput: one command per cycle while the result register is free or
// out_ready is high; the command register feeds one pass of store update and
// column compare into the result register.
// Reset: store cleared, scan at slot 0 of layer 0, config registers at defaults.
module led_cube_frame_scanner (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] mode,
	input  logic [1:0] layer,
	input  logic [3:0] cell_req,
	input  logic [1:0] value,
	input  logic [1:0] axis,
	input  logic       direction,
	input  logic       wrap,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] layer_drive,
	output logic [8:0] column_drive,
	output logic [1:0] read_value,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import lcfs_pkg::*;

	cmd_t       cmd_s1;
	logic       valid_s1;
	logic       advance;
	logic       fire;
	logic [7:0] pwm_period_q;
	logic [7:0] dim_on_q;
	logic [7:0] mid_on_q;
	logic [7:0] full_on_q;
	logic [7:0] slot_q;
	logic [1:0] scan_layer_q;
	logic [7:0] slot_nx;
	logic [1:0] scan_layer_nx;
	logic [7:0] period_eff;
	logic [8:0] slot_inc;
	logic [8:0][1:0] row_levels;
	logic [1:0] read_data;
	logic [8:0] columns;
	logic       out_valid_q;
	logic [2:0] layer_drive_q;
	logic [8:0] column_drive_q;
	logic [1:0] read_value_q;

	// Handshake: the command stage moves on whenever the result register frees.
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Command register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1.mode     <= mode_t'(mode);
			cmd_s1.layer    <= layer;
			cmd_s1.cell_idx <= cell_req;
			cmd_s1.value    <= value;
			cmd_s1.axis     <= axis;
			cmd_s1.up       <= direction;
			cmd_s1.wrap     <= wrap;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= PWM_PERIOD_RST;
			dim_on_q     <= DIM_ON_RST;
			mid_on_q     <= MID_ON_RST;
			full_on_q    <= FULL_ON_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PWM_PERIOD: pwm_period_q <= cfg_data;
				CFG_DIM_ON:     dim_on_q     <= cfg_data;
				CFG_MID_ON:     mid_on_q     <= cfg_data;
				CFG_FULL_ON:    full_on_q    <= cfg_data;
				default:        pwm_period_q <= pwm_period_q;
			endcase
		end
	end

	// Scan counters: the slot runs up to period less one, then the layer advances.
	always_comb begin
		period_eff    = (pwm_period_q == 8'd0) ? 8'd1 : pwm_period_q;
		slot_inc      = {1'b0, slot_q} + 9'd1;
		slot_nx       = slot_q;
		scan_layer_nx = scan_layer_q;
		if (fire && cmd_s1.mode == MODE_SCAN) begin
			if (slot_inc >= {1'b0, period_eff}) begin
				slot_nx       = 8'd0;
				scan_layer_nx = (scan_layer_q >= 2'(NUM_LAYERS - 1)) ? 2'd0
					: scan_layer_q + 2'd1;
			end else begin
				slot_nx = slot_inc[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= 8'd0;
			scan_layer_q <= 2'd0;
		end else begin
			slot_q       <= slot_nx;
			scan_layer_q <= scan_layer_nx;
		end
	end

	// Level and flag store.
	lcfs_voxel_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_s1),
		.apply      (fire),
		.view_layer (scan_layer_nx),
		.row_levels (row_levels),
		.read_data  (read_data)
	);

	// Column compare: lit when the level is non-zero and the slot is below
	// that level's on-time.
	always_comb begin
		logic [7:0] thr;
		for (int j = 0; j < NUM_CELLS; j++) begin
			unique case (row_levels[j])
				2'd1:    thr = dim_on_q;
				2'd2:    thr = mid_on_q;
				2'd3:    thr = full_on_q;
				default: thr = 8'd0;
			endcase
			columns[j] = (row_levels[j] != LEVEL_MIN) && (slot_nx < thr);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			layer_drive_q  <= 3'b001 << scan_layer_nx;
			column_drive_q <= columns;
			read_value_q   <= read_data;
		end
	end

	assign out_valid    = out_valid_q;
	assign layer_drive  = layer_drive_q;
	assign column_drive = column_drive_q;
	assign read_value   = read_value_q;

endmodule

// ----- tb/lcfs_drive_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED cube frame scanner drive checker
// Watches the command, result and register channels of the scanner, keeps its
// own copy of the voxel store and scan counters, predicts the layer drive,
// column drive and read value of every command transaction, and compares each
// result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module lcfs_drive_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [2:0] mode,
	input  logic [1:0] layer,
	input  logic [3:0] cell_req,
	input  logic [1:0] value,
	input  logic [1:0] axis,
	input  logic       direction,
	input  logic       wrap,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [2:0] layer_drive,
	input  logic [8:0] column_drive,
	input  logic [1:0] read_value,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         mismatch_count,
	output int         drives_pending
);
	import lcfs_pkg::*;

	typedef struct packed {
		logic [2:0] layer_drive;
		logic [8:0] column_drive;
		logic [1:0] read_value;
	} drive_t;

	// Predicted drives, oldest first.
	drive_t drive_q[$];

	// Shadow copy of the voxel store, the scan counters and the registers.
	logic [1:0] level_m [NUM_VOXELS];
	logic [1:0] flag_m [NUM_VOXELS];
	logic [7:0] slot_m;
	logic [1:0] scan_m;
	logic [7:0] period_r;
	logic [7:0] dim_r;
	logic [7:0] mid_r;
	logic [7:0] full_r;

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count = mismatch_count + 1;
	endtask

	// Number of lit slots per layer period for a brightness level.
	function automatic logic [7:0] on_slots(input logic [1:0] lvl);
		if (lvl == LEVEL_MAX)
			return full_r;
		else if (lvl == 2'd2)
			return mid_r;
		else if (lvl == 2'd1)
			return dim_r;
		return 8'd0;
	endfunction

	// Moves three voxels on one line, given from low to high index.
	task automatic shift_line(input int a, input int b, input int c, input logic up,
			input logic wrp);
		logic [1:0] va;
		logic [1:0] vb;
		logic [1:0] vc;
		va = level_m[a];
		vb = level_m[b];
		vc = level_m[c];
		if (up) begin
			level_m[c] = vb;
			level_m[b] = va;
			level_m[a] = wrp ? vc : LEVEL_MIN;
		end else begin
			level_m[a] = vb;
			level_m[b] = vc;
			level_m[c] = wrp ? va : LEVEL_MIN;
		end
	endtask

	// Shifts the whole pattern along one axis; an unused axis code does nothing.
	task automatic shift_cube(input logic [1:0] ax, input logic up, input logic wrp);
		int base;
		if (ax == AXIS_X) begin
			for (int i = 0; i < NUM_LAYERS; i++)
				for (int j = 0; j < NUM_ROWS; j++) begin
					base = i * NUM_CELLS + NUM_COLS * j;
					shift_line(base, base + 1, base + 2, up, wrp);
				end
		end else if (ax == AXIS_Y) begin
			for (int i = 0; i < NUM_LAYERS; i++)
				for (int j = 0; j < NUM_COLS; j++) begin
					base = i * NUM_CELLS + j;
					shift_line(base, base + NUM_COLS, base + 2 * NUM_COLS, up, wrp);
				end
		end else if (ax == AXIS_Z) begin
			for (int j = 0; j < NUM_CELLS; j++)
				shift_line(j, j + NUM_CELLS, j + 2 * NUM_CELLS, up, wrp);
		end
	endtask

	// Steps every level by its flag; hold and the spare flag code leave it alone.
	task automatic step_levels();
		for (int i = 0; i < NUM_VOXELS; i++) begin
			if (flag_m[i] == FLAG_UP && level_m[i] != LEVEL_MAX)
				level_m[i] = level_m[i] + 2'd1;
			else if (flag_m[i] == FLAG_DOWN && level_m[i] != LEVEL_MIN)
				level_m[i] = level_m[i] - 2'd1;
		end
	endtask

	// Advances the PWM slot; a period of zero counts as one slot.
	task automatic advance_scan();
		logic [8:0] nxt;
		logic [8:0] per;
		per = (period_r == 8'd0) ? 9'd1 : {1'b0, period_r};
		nxt = {1'b0, slot_m} + 9'd1;
		if (nxt >= per) begin
			slot_m = 8'd0;
			if (int'(scan_m) >= NUM_LAYERS - 1)
				scan_m = 2'd0;
			else
				scan_m = scan_m + 2'd1;
		end else begin
			slot_m = nxt[7:0];
		end
	endtask

	// Applies one command to the shadow state and works out the drive it returns.
	task automatic predict_drive(input logic [2:0] m, input logic [1:0] lay,
			input logic [3:0] cel, input logic [1:0] val, input logic [1:0] ax,
			input logic up, input logic wrp, output drive_t d);
		logic       hit;
		int         addr;
		logic [1:0] rd;
		logic [1:0] lvl;
		logic [8:0] cols;
		hit  = (int'(lay) < NUM_LAYERS) && (int'(cel) < NUM_CELLS);
		addr = hit ? int'(lay) * NUM_CELLS + int'(cel) : 0;
		rd   = 2'd0;
		case (m)
			MODE_SCAN:     advance_scan();
			MODE_WR_LEVEL: if (hit) level_m[addr] = val;
			MODE_RD_LEVEL: if (hit) rd = level_m[addr];
			MODE_WR_FLAG:  if (hit) flag_m[addr] = val;
			MODE_RD_FLAG:  if (hit) rd = flag_m[addr];
			MODE_STEP:     step_levels();
			MODE_SHIFT:    shift_cube(ax, up, wrp);
			default:       ;
		endcase
		cols = '0;
		for (int j = 0; j < NUM_CELLS; j++) begin
			lvl = level_m[int'(scan_m) * NUM_CELLS + j];
			if (lvl != LEVEL_MIN && slot_m < on_slots(lvl))
				cols[j] = 1'b1;
		end
		d.layer_drive  = 3'b001 << scan_m;
		d.column_drive = cols;
		d.read_value   = rd;
	endtask

	// Channel monitor: register writes, result checks, then new predictions.
	always @(posedge clk or negedge arst_n) begin : watch_channels
		drive_t got;
		drive_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOXELS; i++) begin
				level_m[i] = LEVEL_MIN;
				flag_m[i]  = 2'd0;
			end
			slot_m   = 8'd0;
			scan_m   = 2'd0;
			period_r = PWM_PERIOD_RST;
			dim_r    = DIM_ON_RST;
			mid_r    = MID_ON_RST;
			full_r   = FULL_ON_RST;
			drive_q.delete();
			mismatch_count = 0;
			drives_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PWM_PERIOD: period_r = cfg_data;
					CFG_DIM_ON:     dim_r = cfg_data;
					CFG_MID_ON:     mid_r = cfg_data;
					CFG_FULL_ON:    full_r = cfg_data;
				endcase
			end
			if (out_valid && out_ready) begin
				got = {layer_drive, column_drive, read_value};
				if (drive_q.size() == 0) begin
					report_mismatch("result transaction with nothing pending", got, 0);
				end else begin
					want = drive_q.pop_front();
					if (got.layer_drive !== want.layer_drive)
						report_mismatch("layer_drive", got.layer_drive, want.layer_drive);
					if (got.column_drive !== want.column_drive)
						report_mismatch("column_drive", got.column_drive, want.column_drive);
					if (got.read_value !== want.read_value)
						report_mismatch("read_value", got.read_value, want.read_value);
				end
			end
			if (in_valid && in_ready) begin
				predict_drive(mode, layer, cell_req, value, axis, direction, wrap, want);
				drive_q.push_back(want);
			end
			drives_pending <= drive_q.size();
		end
	end

endmodule

// ----- tb/tb_led_cube_frame_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED cube frame scanner testbench
// Drives directed and random command streams through the scanner under several
// register settings, with bursty command traffic and a stalling result side,
// and leaves prediction and comparison to the drive checker.
// ----------------------------------------------------------------------------
module tb_led_cube_frame_scanner;
	import lcfs_pkg::*;

	localparam int IDLE_LIMIT = 1000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] mode = MODE_SCAN;
	logic [1:0] layer = 2'd0;
	logic [3:0] cell_req = 4'd0;
	logic [1:0] value = 2'd0;
	logic [1:0] axis = AXIS_X;
	logic       direction = 1'b0;
	logic       wrap = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b1;
	logic [2:0] layer_drive;
	logic [8:0] column_drive;
	logic [1:0] read_value;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = CFG_PWM_PERIOD;
	logic [7:0] cfg_data = 8'd0;

	int         mismatch_count;
	int         drives_pending;
	int         burst_left = 0;
	int         idle_cycles = 0;
	logic [5:0] stall_tick = '0;
	logic [1:0] stall_style = 2'd0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	led_cube_frame_scanner u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.layer        (layer),
		.cell_req     (cell_req),
		.value        (value),
		.axis         (axis),
		.direction    (direction),
		.wrap         (wrap),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.layer_drive  (layer_drive),
		.column_drive (column_drive),
		.read_value   (read_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	lcfs_drive_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.layer          (layer),
		.cell_req       (cell_req),
		.value          (value),
		.axis           (axis),
		.direction      (direction),
		.wrap           (wrap),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.layer_drive    (layer_drive),
		.column_drive   (column_drive),
		.read_value     (read_value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.drives_pending (drives_pending)
	);

	// Result side stalls; the style changes each time the 6-bit stall tick wraps.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 6'd1;
		if (stall_tick == '0)
			stall_style <= $urandom_range(0, 3);
		case (stall_style)
			2'd0:    out_ready <= 1'b1;
			2'd1:    out_ready <= $urandom_range(0, 1);
			2'd2:    out_ready <= (stall_tick[2:0] == 3'd0);
			default: out_ready <= stall_tick[1];
		endcase
	end

	// Watchdog: ends the run when no transaction happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Sends one command transaction; bursts end in a random gap.
	task automatic send_cmd(input logic [2:0] m, input logic [1:0] lay,
			input logic [3:0] cel, input logic [1:0] val, input logic [1:0] ax,
			input logic dir, input logic wrp);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left = burst_left - 1;
		in_valid  <= 1'b1;
		mode      <= m;
		layer     <= lay;
		cell_req  <= cel;
		value     <= val;
		axis      <= ax;
		direction <= dir;
		wrap      <= wrp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Holds off commands until every predicted drive has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (drives_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one register; the caller lowers cfg_valid after the last one.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_setting(input logic [7:0] per, input logic [7:0] dim,
			input logic [7:0] mid, input logic [7:0] full);
		write_reg(CFG_PWM_PERIOD, per);
		write_reg(CFG_DIM_ON, dim);
		write_reg(CFG_MID_ON, mid);
		write_reg(CFG_FULL_ON, full);
		cfg_valid <= 1'b0;
	endtask

	// Random command: mostly well-formed with valid addresses, some noise.
	task automatic random_cmd();
		int         pick;
		logic [1:0] lay;
		logic [3:0] cel;
		logic [1:0] val;
		logic [1:0] ax;
		logic       dir;
		logic       wrp;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) begin
			lay = $urandom_range(0, 3);
			cel = $urandom_range(0, 15);
		end else begin
			lay = $urandom_range(0, 2);
			cel = $urandom_range(0, 8);
		end
		val = $urandom_range(0, 3);
		ax  = $urandom_range(0, 3);
		dir = $urandom_range(0, 1);
		wrp = $urandom_range(0, 1);
		if (pick < 35)
			send_cmd(MODE_SCAN, lay, cel, val, ax, dir, wrp);
		else if (pick < 55)
			send_cmd(MODE_WR_LEVEL, lay, cel, val, ax, dir, wrp);
		else if (pick < 65)
			send_cmd(MODE_RD_LEVEL, lay, cel, val, ax, dir, wrp);
		else if (pick < 72)
			send_cmd(MODE_WR_FLAG, lay, cel, val, ax, dir, wrp);
		else if (pick < 78)
			send_cmd(MODE_RD_FLAG, lay, cel, val, ax, dir, wrp);
		else if (pick < 84)
			send_cmd(MODE_STEP, lay, cel, val, ax, dir, wrp);
		else if (pick < 94)
			send_cmd(MODE_SHIFT, lay, cel, val, 2'($urandom_range(0, 2)), dir, wrp);
		else
			send_cmd(3'($urandom_range(0, 7)), lay, cel, val, ax, dir, wrp);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads after reset, out-of-range addresses, flags and stepping.
		send_cmd(MODE_RD_LEVEL, 2'd0, 4'd0, 2'd0, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_WR_LEVEL, 2'd0, 4'd0, LEVEL_MAX, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_WR_LEVEL, 2'd0, 4'd8, 2'd1, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_WR_LEVEL, 2'd2, 4'd4, 2'd2, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_WR_LEVEL, 2'd3, 4'd0, LEVEL_MAX, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_WR_LEVEL, 2'd0, 4'd15, LEVEL_MAX, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_RD_LEVEL, 2'd3, 4'd0, 2'd0, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_RD_LEVEL, 2'd0, 4'd9, 2'd0, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_WR_FLAG, 2'd0, 4'd8, FLAG_UP, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_WR_FLAG, 2'd0, 4'd0, FLAG_DOWN, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_WR_FLAG, 2'd2, 4'd4, 2'd3, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_RD_FLAG, 2'd2, 4'd4, 2'd0, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_STEP, 2'd0, 4'd0, 2'd0, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_RD_LEVEL, 2'd0, 4'd8, 2'd0, AXIS_X, 1'b0, 1'b0);

		// Directed: every axis both ways, with and without wrap, and unused codes.
		send_cmd(MODE_SHIFT, 2'd0, 4'd0, 2'd0, AXIS_X, 1'b1, 1'b1);
		send_cmd(MODE_SHIFT, 2'd0, 4'd0, 2'd0, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_SHIFT, 2'd0, 4'd0, 2'd0, AXIS_Y, 1'b1, 1'b0);
		send_cmd(MODE_SHIFT, 2'd0, 4'd0, 2'd0, AXIS_Y, 1'b0, 1'b1);
		send_cmd(MODE_SHIFT, 2'd0, 4'd0, 2'd0, AXIS_Z, 1'b1, 1'b1);
		send_cmd(MODE_SHIFT, 2'd0, 4'd0, 2'd0, AXIS_Z, 1'b0, 1'b0);
		send_cmd(MODE_SHIFT, 2'd0, 4'd0, 2'd0, 2'd3, 1'b1, 1'b1);
		send_cmd(3'd7, 2'd0, 4'd0, 2'd0, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_SCAN, 2'd0, 4'd0, 2'd0, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_SCAN, 2'd0, 4'd0, 2'd0, AXIS_X, 1'b0, 1'b0);
		send_cmd(MODE_SCAN, 2'd0, 4'd0, 2'd0, AXIS_X, 1'b0, 1'b0);

		// Random phases under different register settings.
		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case (ph)
				0: load_setting(8'd1, 8'd0, 8'd255, 8'd128);
				1: load_setting(8'd255, 8'd255, 8'd0, 8'd3);
				// Period drops below the slot reached in the previous phase.
				2: load_setting(8'd3, 8'd1, 8'd2, 8'd3);
				3: load_setting(8'd0, 8'd1, 8'd0, 8'd255);
				default: load_setting($urandom_range(1, 12), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255));
			endcase
			for (int n = 0; n < 65; n++) begin
				if (n == 32)
					wait_idle();
				random_cmd();
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && drives_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
